// ----- rtl/line_start_offset_index_core_macros.svh -----
// Assertion macros for the line start offset index core.
// Used by the top level; needs a clk and arst_n in scope where used.
`ifndef LINE_START_OFFSET_INDEX_CORE_MACROS_SVH
`define LINE_START_OFFSET_INDEX_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LSOI_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsoi assertion failed");
`define LSOI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsoi assertion failed");
`else
`define LSOI_ASSERT_SAME(label, ante, cons)
`define LSOI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/lsoi_pkg.sv -----
// Shared types and constants of the line start offset index core.
// No dependencies.
`default_nettype none
package lsoi_pkg;
	localparam int MAX_LINES   = 1024;
	localparam int OFFSET_BITS = 24;
	localparam int IDX_W       = $clog2(MAX_LINES);
	localparam int CNT_W       = IDX_W + 1;

	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_BYTE   = 3'd1;
	localparam logic [2:0] CMD_INSERT = 3'd2;
	localparam logic [2:0] CMD_ERASE  = 3'd3;
	localparam logic [2:0] CMD_QUERY  = 3'd4;

	localparam logic [7:0] NEWLINE = 8'd10;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LATCH, OP_CLEAR, OP_BYTE, OP_SH_RD, OP_SH_WR, OP_SPL_WR,
		OP_INS_INIT, OP_INS_WR, OP_INS_END, OP_ERA_INIT, OP_ERA_WR,
		OP_ERA_END, OP_RD, OP_QFIN, OP_OUT
	} dp_op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_SH_CHK, S_SH_RD, S_SH_WR, S_SPL, S_INS_CHK,
		S_INS_RD, S_INS_WR, S_INS_END, S_ERA_CHK, S_ERA_RD, S_ERA_WR,
		S_ERA_END, S_Q_RD, S_Q_FIN, S_RES
	} state_t;

	typedef struct packed {
		dp_op_t op;
		logic   in_ready;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [2:0]       cmd;
		logic             is_nl;
		logic             full;
		logic             len_zero;
		logic             ptr_ge_cur;
		logic             ptr_lt_count;
		logic             out_free;
		logic [CNT_W-1:0] count;
	} dp_stat_t;
endpackage
`default_nettype wire

// ----- rtl/lsoi_in_if.sv -----
// Input channel of the line start offset index core: one command beat.
// Depends on lsoi_pkg.
`default_nettype none
interface lsoi_in_if import lsoi_pkg::*; ;
	logic                   valid;
	logic                   ready;
	logic [2:0]             command;
	logic [OFFSET_BITS-1:0] position;
	logic [OFFSET_BITS-1:0] length;
	logic [7:0]             text_byte;
	logic [IDX_W-1:0]       line_number;
	modport source (output valid, command, position, length, text_byte, line_number,
		input ready);
	modport sink (input valid, command, position, length, text_byte, line_number,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/lsoi_out_if.sv -----
// Output channel of the line start offset index core: one result beat.
// Depends on lsoi_pkg.
`default_nettype none
interface lsoi_out_if import lsoi_pkg::*; ;
	logic                   valid;
	logic                   ready;
	logic [OFFSET_BITS-1:0] start_offset;
	logic [CNT_W-1:0]       line_count;
	logic [1:0]             status;
	modport source (output valid, start_offset, line_count, status, input ready);
	modport sink (input valid, start_offset, line_count, status, output ready);
endinterface
`default_nettype wire

// ----- rtl/line_start_offset_index_core.sv -----
// Line start offset index core. A newline byte on a table that is not full walks the
// shifted entries, and a nonzero insert or erase walks every entry past entry zero,
// over the single-port table memory; clear, other bytes, zero-length edits, unknown
// commands and queries do no walk. A stalled result beat adds its wait.
// A result beat may wait in the output register while the next command is accepted.
// Reset (arst_n, asynchronous) leaves one entry at offset zero and the scan at zero.
`default_nettype none
`include "line_start_offset_index_core_macros.svh"
module line_start_offset_index_core import lsoi_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	lsoi_in_if.sink    in_ch,
	lsoi_out_if.source out_ch
);
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	assign in_ch.ready = cmd.in_ready;

	// sequencer
	lsoi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	lsoi_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.in_command       (in_ch.command),
		.in_position      (in_ch.position),
		.in_length        (in_ch.length),
		.in_text_byte     (in_ch.text_byte),
		.in_line_number   (in_ch.line_number),
		.out_ready        (out_ch.ready),
		.stat             (stat),
		.out_valid        (out_ch.valid),
		.out_start_offset (out_ch.start_offset),
		.out_line_count   (out_ch.line_count),
		.out_status       (out_ch.status)
	);

	// checks
	`LSOI_ASSERT_SAME(a_count_range, 1'b1, stat.count >= 1 && stat.count <= MAX_LINES)
	`LSOI_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
	`LSOI_ASSERT_SAME(a_range_zero, out_ch.valid && out_ch.status == ST_RANGE, out_ch.start_offset == 0)
	`LSOI_ASSERT_SAME(a_no_busy_write, cmd.op == OP_LATCH, in_ch.ready)
endmodule
`default_nettype wire

// ----- rtl/lsoi_ctrl.sv -----
// Sequencer of the line start offset index core.
// Depends on lsoi_pkg; drives the datapath through ctrl_cmd_t.
`default_nettype none
module lsoi_ctrl import lsoi_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);
	state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// next state and datapath command
	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LATCH;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (stat.cmd)
					CMD_CLEAR: begin
						cmd.op  = OP_CLEAR;
						state_d = S_RES;
					end
					CMD_BYTE: begin
						cmd.op  = OP_BYTE;
						state_d = (stat.is_nl && !stat.full) ? S_SH_CHK : S_RES;
					end
					CMD_INSERT: begin
						if (stat.len_zero) state_d = S_RES;
						else begin
							cmd.op  = OP_INS_INIT;
							state_d = S_INS_CHK;
						end
					end
					CMD_ERASE: begin
						if (stat.len_zero) state_d = S_RES;
						else begin
							cmd.op  = OP_ERA_INIT;
							state_d = S_ERA_CHK;
						end
					end
					CMD_QUERY: state_d = S_Q_RD;
					default: state_d = S_RES;
				endcase
			end
			S_SH_CHK: state_d = stat.ptr_ge_cur ? S_SH_RD : S_SPL;
			S_SH_RD: begin
				cmd.op  = OP_SH_RD;
				state_d = S_SH_WR;
			end
			S_SH_WR: begin
				cmd.op  = OP_SH_WR;
				state_d = S_SH_CHK;
			end
			S_SPL: begin
				cmd.op  = OP_SPL_WR;
				state_d = S_RES;
			end
			S_INS_CHK: state_d = stat.ptr_lt_count ? S_INS_RD : S_INS_END;
			S_INS_RD: begin
				cmd.op  = OP_SH_RD;
				state_d = S_INS_WR;
			end
			S_INS_WR: begin
				cmd.op  = OP_INS_WR;
				state_d = S_INS_CHK;
			end
			S_INS_END: begin
				cmd.op  = OP_INS_END;
				state_d = S_RES;
			end
			S_ERA_CHK: state_d = stat.ptr_lt_count ? S_ERA_RD : S_ERA_END;
			S_ERA_RD: begin
				cmd.op  = OP_SH_RD;
				state_d = S_ERA_WR;
			end
			S_ERA_WR: begin
				cmd.op  = OP_ERA_WR;
				state_d = S_ERA_CHK;
			end
			S_ERA_END: begin
				cmd.op  = OP_ERA_END;
				state_d = S_RES;
			end
			S_Q_RD: begin
				cmd.op  = OP_RD;
				state_d = S_Q_FIN;
			end
			S_Q_FIN: begin
				cmd.op  = OP_QFIN;
				state_d = S_RES;
			end
			S_RES: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/lsoi_dp.sv -----
// Datapath of the line start offset index core: table memory, counters, result register.
// Depends on lsoi_pkg; commanded by lsoi_ctrl.
`default_nettype none
module lsoi_dp import lsoi_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  ctrl_cmd_t                   cmd,
	input  wire logic [2:0]             in_command,
	input  wire logic [OFFSET_BITS-1:0] in_position,
	input  wire logic [OFFSET_BITS-1:0] in_length,
	input  wire logic [7:0]             in_text_byte,
	input  wire logic [IDX_W-1:0]       in_line_number,
	input  wire logic                   out_ready,
	output dp_stat_t                    stat,
	output logic                        out_valid,
	output logic [OFFSET_BITS-1:0]      out_start_offset,
	output logic [CNT_W-1:0]            out_line_count,
	output logic [1:0]                  out_status
);
	logic [OFFSET_BITS-1:0] line_starts_q [MAX_LINES];
	logic [OFFSET_BITS-1:0] rdata_q;

	logic [2:0]             cmd_q;
	logic [OFFSET_BITS-1:0] pos_q, len_q;
	logic [7:0]             byte_q;
	logic [IDX_W-1:0]       line_q;

	logic [CNT_W-1:0]       count_q, cursor_q, cur_q, ptr_q, keep_q, first_q;
	logic [OFFSET_BITS-1:0] base_q, index_q, off_q, res_q;
	logic                   found_q;
	status_t                stat_q;
	logic                   out_valid_q;

	logic [CNT_W-1:0]       ptr_inc, cur_clamp;
	logic [OFFSET_BITS:0]   hi;
	logic                   v_gt_pos, v_gt_hi, line_ok;
	logic                   wr_en, rd_en;
	logic [IDX_W-1:0]       wr_addr, rd_addr;
	logic [OFFSET_BITS-1:0] wr_data;

	assign ptr_inc  = ptr_q + CNT_W'(1);
	assign hi       = {1'b0, pos_q} + {1'b0, len_q};
	assign v_gt_pos = rdata_q > pos_q;
	assign v_gt_hi  = {1'b0, rdata_q} > hi;
	assign line_ok  = {1'b0, line_q} < count_q;

	// clamp the splice cursor into 1..count
	always_comb begin
		cur_clamp = cursor_q;
		if (cur_clamp > count_q) cur_clamp = count_q;
		if (cur_clamp < CNT_W'(1)) cur_clamp = CNT_W'(1);
	end

	// status toward the sequencer
	assign stat.cmd          = cmd_q;
	assign stat.is_nl        = byte_q == NEWLINE;
	assign stat.full         = count_q >= CNT_W'(MAX_LINES);
	assign stat.len_zero     = len_q == '0;
	assign stat.ptr_ge_cur   = ptr_q >= cur_q;
	assign stat.ptr_lt_count = ptr_q < count_q;
	assign stat.out_free     = !out_valid_q || out_ready;
	assign stat.count        = count_q;

	// memory port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q[IDX_W-1:0];
		wr_data = rdata_q;
		rd_en   = 1'b0;
		rd_addr = ptr_q[IDX_W-1:0];
		unique case (cmd.op)
			OP_SH_RD: rd_en = 1'b1;
			OP_RD: begin
				rd_en   = 1'b1;
				rd_addr = line_q;
			end
			OP_SH_WR: begin
				wr_en   = 1'b1;
				wr_addr = ptr_inc[IDX_W-1:0];
			end
			OP_SPL_WR: begin
				wr_en   = 1'b1;
				wr_addr = cur_q[IDX_W-1:0];
				wr_data = off_q;
			end
			OP_INS_WR: begin
				wr_en   = found_q || v_gt_pos;
				wr_data = rdata_q + len_q;
			end
			OP_ERA_WR: begin
				wr_en   = !(v_gt_pos && !v_gt_hi);
				wr_addr = keep_q[IDX_W-1:0];
				wr_data = v_gt_hi ? rdata_q - len_q : rdata_q;
			end
			default: ;
		endcase
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) line_starts_q[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= line_starts_q[rd_addr];
	end

	// latch the beat payload
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LATCH) begin
			cmd_q  <= in_command;
			pos_q  <= in_position;
			len_q  <= in_length;
			byte_q <= in_text_byte;
			line_q <= in_line_number;
		end
	end

	// table state and scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= CNT_W'(1);
			cursor_q <= CNT_W'(1);
			base_q   <= '0;
			index_q  <= '0;
		end else begin
			unique case (cmd.op)
				OP_CLEAR: begin
					count_q  <= CNT_W'(1);
					cursor_q <= CNT_W'(1);
					base_q   <= '0;
					index_q  <= '0;
				end
				OP_BYTE: index_q <= index_q + OFFSET_BITS'(1);
				OP_SPL_WR: begin
					count_q  <= count_q + CNT_W'(1);
					cursor_q <= cur_q + CNT_W'(1);
				end
				OP_INS_END: begin
					base_q   <= pos_q;
					index_q  <= '0;
					cursor_q <= first_q;
				end
				OP_ERA_END: count_q <= keep_q;
				default: ;
			endcase
		end
	end

	// walk pointers and result staging
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LATCH: begin
				res_q  <= '0;
				stat_q <= ST_OK;
			end
			OP_BYTE: begin
				off_q <= base_q + index_q + OFFSET_BITS'(1);
				cur_q <= cur_clamp;
				ptr_q <= count_q - CNT_W'(1);
				if (byte_q == NEWLINE && count_q >= CNT_W'(MAX_LINES)) stat_q <= ST_FULL;
			end
			OP_SH_WR: ptr_q <= ptr_q - CNT_W'(1);
			OP_INS_INIT: begin
				ptr_q   <= CNT_W'(1);
				found_q <= 1'b0;
				first_q <= count_q;
			end
			OP_INS_WR: begin
				if (!found_q && v_gt_pos) begin
					found_q <= 1'b1;
					first_q <= ptr_q;
				end
				ptr_q <= ptr_inc;
			end
			OP_ERA_INIT: begin
				ptr_q  <= CNT_W'(1);
				keep_q <= CNT_W'(1);
			end
			OP_ERA_WR: begin
				if (!(v_gt_pos && !v_gt_hi)) keep_q <= keep_q + CNT_W'(1);
				ptr_q <= ptr_inc;
			end
			OP_QFIN: begin
				if (!line_ok) stat_q <= ST_RANGE;
				else if (line_q != '0) res_q <= rdata_q;
			end
			default: ;
		endcase
	end

	// output register: load on finish, drop on a taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.op == OP_OUT) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			out_start_offset <= res_q;
			out_line_count   <= count_q;
			out_status       <= stat_q;
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// ----- tb/line_start_offset_index_core_tb.sv -----
// Self-checking testbench for line_start_offset_index_core: directed and random
// command beats, each checked against an in-bench model of the offset table.
// Depends on lsoi_pkg, lsoi_in_if, lsoi_out_if and the core itself.
`default_nettype none
module line_start_offset_index_core_tb;
	import lsoi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CYCLE_LIMIT = 20000000;
	localparam int          DRAIN_WAIT  = 3 * MAX_LINES + 64;
	localparam logic [2:0]  CMD_LAST    = 3'd7;
	localparam logic [23:0] OFS_MAX     = 24'hFFFFFF;

	typedef struct packed {
		logic [23:0] start_offset;
		logic [10:0] line_count;
		logic [1:0]  status;
	} line_result_t;

	logic clk;
	logic arst_n;
	int   cycles;
	int   errors;
	int   send_idle_pct;
	int   recv_stall_pct;

	lsoi_in_if  cmd_bus();
	lsoi_out_if res_bus();

	line_start_offset_index_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (cmd_bus),
		.out_ch (res_bus)
	);

	// Model of the offset table and the text scan
	logic [23:0]  line_tbl [MAX_LINES];
	int           n_lines;
	logic [23:0]  scan_base;
	logic [23:0]  scan_idx;
	int           scan_cur;
	line_result_t pending_results [$];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("status: fail");
			$finish;
		end
	end

	// Randomly stall the result channel
	always @(negedge clk) begin
		res_bus.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin
		line_result_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: offset %0d count %0d status %0d", $time,
					res_bus.start_offset, res_bus.line_count, res_bus.status);
				errors = errors + 1;
			end else begin
				want = pending_results.pop_front();
				if (res_bus.start_offset !== want.start_offset) begin
					$display("%0t start_offset mismatch: expected %0d actual %0d", $time,
						want.start_offset, res_bus.start_offset);
					errors = errors + 1;
				end
				if (res_bus.line_count !== want.line_count) begin
					$display("%0t line_count mismatch: expected %0d actual %0d", $time,
						want.line_count, res_bus.line_count);
					errors = errors + 1;
				end
				if (res_bus.status !== want.status) begin
					$display("%0t status mismatch: expected %0d actual %0d", $time,
						want.status, res_bus.status);
					errors = errors + 1;
				end
			end
		end
	end

	function automatic void clear_table();
		foreach (line_tbl[i]) line_tbl[i] = '0;
		n_lines   = 1;
		scan_base = '0;
		scan_idx  = '0;
		scan_cur  = 1;
	endfunction

	// Advance the scan by one byte; splice a newline offset at the cursor
	function automatic status_t splice_text_byte(logic [7:0] byt);
		logic [23:0] off;
		int          cur;
		off      = scan_base + scan_idx + 24'd1;
		scan_idx = scan_idx + 24'd1;
		if (byt != NEWLINE) return ST_OK;
		if (n_lines >= MAX_LINES) return ST_FULL;
		cur = scan_cur;
		if (cur > n_lines) cur = n_lines;
		if (cur < 1) cur = 1;
		for (int i = n_lines; i > cur; i--) line_tbl[i] = line_tbl[i-1];
		line_tbl[cur] = off;
		n_lines++;
		scan_cur = cur + 1;
		return ST_OK;
	endfunction

	// Shift entries above pos up by len and reopen the cursor there
	function automatic void open_insert(logic [23:0] pos, logic [23:0] len);
		int first;
		if (len == '0) return;
		first = n_lines;
		for (int i = 0; i < n_lines; i++) begin
			if (line_tbl[i] > pos) begin
				first = i;
				break;
			end
		end
		for (int i = first; i < n_lines; i++) line_tbl[i] = line_tbl[i] + len;
		scan_base = pos;
		scan_idx  = '0;
		scan_cur  = first;
	endfunction

	// Drop entries in (pos, pos+len], pull later ones down by len
	function automatic void erase_span(logic [23:0] pos, logic [23:0] len);
		logic [24:0] hi;
		logic [24:0] v;
		int          keep;
		if (len == '0) return;
		hi   = {1'b0, pos} + {1'b0, len};
		keep = 1;
		for (int i = 1; i < n_lines; i++) begin
			v = {1'b0, line_tbl[i]};
			if (v > {1'b0, pos} && v <= hi) continue;
			line_tbl[keep] = (v > hi) ? line_tbl[i] - len : line_tbl[i];
			keep++;
		end
		for (int i = keep; i < n_lines; i++) line_tbl[i] = '0;
		n_lines = keep;
	endfunction

	function automatic line_result_t apply_command(logic [2:0] cmd, logic [23:0] pos,
			logic [23:0] len, logic [7:0] byt, logic [9:0] line);
		line_result_t r;
		r.start_offset = '0;
		r.status       = ST_OK;
		case (cmd)
			CMD_CLEAR: clear_table();
			CMD_BYTE: r.status = splice_text_byte(byt);
			CMD_INSERT: open_insert(pos, len);
			CMD_ERASE: erase_span(pos, len);
			CMD_QUERY: begin
				if (line < n_lines) r.start_offset = line_tbl[line];
				else r.status = ST_RANGE;
			end
			default: ;
		endcase
		r.line_count = n_lines[10:0];
		return r;
	endfunction

	// Drive one command beat, with random idle cycles first, and predict its result
	task automatic send_cmd(logic [2:0] cmd, logic [23:0] pos = '0, logic [23:0] len = '0,
			logic [7:0] byt = '0, logic [9:0] line = '0);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid       <= 1'b1;
		cmd_bus.command     <= cmd;
		cmd_bus.position    <= pos;
		cmd_bus.length      <= len;
		cmd_bus.text_byte   <= byt;
		cmd_bus.line_number <= line;
		do @(posedge clk); while (!cmd_bus.ready);
		pending_results = {pending_results, apply_command(cmd, pos, len, byt, line)};
	endtask

	task automatic send_text(int n, int nl_pct);
		for (int i = 0; i < n; i++)
			send_cmd(CMD_BYTE, 24'($urandom), 24'($urandom),
				($urandom_range(99) < nl_pct) ? NEWLINE : 8'($urandom));
	endtask

	task automatic test_directed();
		send_cmd(CMD_QUERY, '0, '0, '0, 10'd0);
		send_cmd(CMD_QUERY, '0, '0, '0, 10'd1023);
		send_cmd(CMD_CLEAR);
		send_cmd(CMD_BYTE, '0, '0, 8'hFF);
		send_cmd(CMD_BYTE, '0, '0, NEWLINE);
		send_cmd(CMD_BYTE, '0, '0, 8'h00);
		send_cmd(CMD_BYTE, '0, '0, NEWLINE);
		send_cmd(CMD_INSERT, 24'd0, 24'd0);
		send_cmd(CMD_ERASE, 24'd1, 24'd0);
		send_cmd(CMD_INSERT, 24'd1, 24'd3);
		// splice more newlines than the opened length
		send_text(4, 100);
		send_cmd(CMD_QUERY, '0, '0, '0, 10'd3);
		// erase that leaves the cursor stale, then splice
		send_cmd(CMD_ERASE, 24'd0, 24'd5);
		send_cmd(CMD_BYTE, '0, '0, NEWLINE);
		// shift past the top of the offset range
		send_cmd(CMD_INSERT, 24'd0, OFS_MAX);
		send_cmd(CMD_BYTE, '0, '0, NEWLINE);
		send_cmd(CMD_QUERY, '0, '0, '0, 10'd1);
		send_cmd(CMD_ERASE, OFS_MAX, OFS_MAX);
		for (logic [2:0] c = CMD_QUERY + 3'd1; c != '0; c++)
			send_cmd(c, OFS_MAX, OFS_MAX, 8'hFF, 10'h3FF);
		send_cmd(CMD_QUERY, '0, '0, '0, 10'h3FF);
	endtask

	// Mostly well-formed edit sequences on a small table, some noise
	task automatic test_random(int n_items, int idle_pct, int stall_pct);
		int sent;
		int pick;
		int top;
		logic [23:0] pos;
		logic [23:0] len;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			top  = int'(line_tbl[n_lines-1]) + 8;
			pos  = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(top));
			len  = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(12));
			if (n_lines > 60 || pick < 5) begin
				send_cmd(CMD_CLEAR);
				sent++;
			end else if (pick < 35) begin
				send_text($urandom_range(1, 8), 35);
				sent += 4;
			end else if (pick < 55) begin
				send_cmd(CMD_INSERT, pos, len);
				send_text($urandom_range(0, 5), 40);
				sent += 3;
			end else if (pick < 65) begin
				send_cmd(CMD_ERASE, pos, len);
				sent++;
			end else if (pick < 88) begin
				send_cmd(CMD_QUERY, 24'($urandom), 24'($urandom), 8'($urandom),
					($urandom_range(7) == 0) ? 10'($urandom) :
					10'($urandom_range(n_lines + 1)));
				sent++;
			end else begin
				send_cmd(3'($urandom_range(CMD_LAST)), 24'($urandom), 24'($urandom),
					8'($urandom), 10'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		cycles              = 0;
		errors              = 0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		arst_n              = 1'b0;
		cmd_bus.valid       = 1'b0;
		cmd_bus.command     = CMD_CLEAR;
		cmd_bus.position    = '0;
		cmd_bus.length      = '0;
		cmd_bus.text_byte   = '0;
		cmd_bus.line_number = '0;
		res_bus.ready       = 1'b0;
		clear_table();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(138, 0, 0);
		test_random(138, 88, 0);
		test_random(138, 0, 88);
		test_random(138, 14, 14);

		// Release the input, drain outstanding results, then settle
		@(negedge clk);
		cmd_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire
